// ----- hw/rtl/fixed_block_pool_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator: assertion macros
// Shorthands for clocked properties on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FBPA_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Sizing constants, codes and the structs shared by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

  // Pool geometry
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned ALIGN_BYTES  = 16;   // power of two
  localparam int unsigned MAX_SLOTS    = 1024;

  localparam int unsigned SLOT_IDX_W = $clog2(MAX_SLOTS);
  localparam int unsigned HANDED_W   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned STRIDE_W   = 16;
  localparam int unsigned RSTRIDE_W  = STRIDE_W + 1;
  localparam int unsigned SLOT_W     =
    $clog2(HEADER_BYTES + ((65535 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES + 1);
  localparam int unsigned MUL_A_W    = (HANDED_W > 16) ? HANDED_W : 16;
  localparam int unsigned PROD_W     = MUL_A_W + SLOT_W;
  localparam int unsigned DIST_W     = 34;
  localparam int unsigned CMP_W      = (PROD_W > DIST_W - 1) ? PROD_W : DIST_W - 1;
  localparam int unsigned REM_W      = SLOT_IDX_W + SLOT_W;
  localparam int unsigned STEP_W     = $clog2(SLOT_IDX_W + 1);
  localparam int unsigned RAM_W      = SLOT_IDX_W + 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd2;

  // Operation codes
  localparam logic [1:0] OP_RESERVE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_REQ     = 3'd1,
    ST_EXHAUSTED   = 3'd2,
    ST_NULL        = 3'd3,
    ST_RANGE       = 3'd4,
    ST_MISALIGNED  = 3'd5,
    ST_DOUBLE_FREE = 3'd6
  } status_e;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MUL_REQ   = 2'd0,   // item_count * elem_size
    MUL_BUMP  = 2'd1,   // (handed + 1) * slot bytes
    MUL_LIMIT = 2'd2,   // handed * slot bytes
    MUL_SLOT  = 2'd3    // slot * slot bytes
  } mul_sel_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] item_count;
    logic [15:0] elem_size;
    logic [31:0] payload_address;
    logic        address_is_null;
  } fbpa_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
  } fbpa_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     dist_en;
    logic     div_init;
    logic     div_step;
    logic     ram_addr_head;
    logic     pop_take;
    logic     pop_link;
    logic     bump;
    logic     mark_used;
    logic     push;
    logic     clear;
    logic     addr_en;
    logic     set_status;
    status_e  status;
  } fbpa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       is_null;
    logic       req_bad;
    logic       list_empty;
    logic       handed_full;
    logic       bump_over;
    logic       range_bad;
    logic       div_last;
    logic       misaligned;
    logic       double_free;
  } fbpa_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fbpa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read of the same address per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fbpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator controller
// Sequences reserve, release and clear transactions over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  output logic                     done_o,
  input  wire fbpa_pkg::fbpa_sts_t sts_i,
  output fbpa_pkg::fbpa_cmd_t      cmd_o
);

  import fbpa_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_DECODE    = 14'b00000000000010,
    S_RSV_SIZE  = 14'b00000000000100,
    S_RSV_CHECK = 14'b00000000001000,
    S_POP       = 14'b00000000010000,
    S_BUMP      = 14'b00000000100000,
    S_ADDR_MUL  = 14'b00000001000000,
    S_ADDR_ADD  = 14'b00000010000000,
    S_REL_RANGE = 14'b00000100000000,
    S_REL_CHECK = 14'b00001000000000,
    S_DIV       = 14'b00010000000000,
    S_REL_ALIGN = 14'b00100000000000,
    S_REL_FREE  = 14'b01000000000000,
    S_DONE      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_RESERVE: state_d = S_RSV_SIZE;
          OP_RELEASE: begin
            if (sts_i.is_null) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NULL;
              state_d          = S_DONE;
            end else begin
              state_d = S_REL_RANGE;
            end
          end
          OP_CLEAR: begin
            cmd_o.clear      = 1'b1;
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_OK;
            state_d          = S_DONE;
          end
          default: begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_BAD_REQ;
            state_d          = S_DONE;
          end
        endcase
      end
      // Request size product
      S_RSV_SIZE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_REQ;
        state_d       = S_RSV_CHECK;
      end
      // Reject a bad request, else pick free list or bump, or report exhaustion
      S_RSV_CHECK: begin
        if (sts_i.req_bad) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_BAD_REQ;
          state_d          = S_DONE;
        end else if (!sts_i.list_empty) begin
          cmd_o.pop_take      = 1'b1;
          cmd_o.ram_addr_head = 1'b1;
          state_d             = S_POP;
        end else if (sts_i.handed_full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_EXHAUSTED;
          state_d          = S_DONE;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_BUMP;
          state_d       = S_BUMP;
        end
      end
      S_POP: begin
        cmd_o.pop_link = 1'b1;
        state_d        = S_ADDR_MUL;
      end
      S_BUMP: begin
        if (sts_i.bump_over) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_EXHAUSTED;
          state_d          = S_DONE;
        end else begin
          cmd_o.bump = 1'b1;
          state_d    = S_ADDR_MUL;
        end
      end
      S_ADDR_MUL: begin
        cmd_o.mark_used = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_SLOT;
        state_d         = S_ADDR_ADD;
      end
      S_ADDR_ADD: begin
        cmd_o.addr_en    = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = ST_OK;
        state_d          = S_DONE;
      end
      // Release: offset and bump mark in parallel
      S_REL_RANGE: begin
        cmd_o.dist_en = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LIMIT;
        state_d       = S_REL_CHECK;
      end
      S_REL_CHECK: begin
        if (sts_i.range_bad) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_RANGE;
          state_d          = S_DONE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_REL_ALIGN;
        end
      end
      // Remainder check; RAM read of the slot entry
      S_REL_ALIGN: begin
        if (sts_i.misaligned) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_MISALIGNED;
          state_d          = S_DONE;
        end else begin
          state_d = S_REL_FREE;
        end
      end
      S_REL_FREE: begin
        cmd_o.set_status = 1'b1;
        if (sts_i.double_free) begin
          cmd_o.status = ST_DOUBLE_FREE;
        end else begin
          cmd_o.push   = 1'b1;
          cmd_o.status = ST_OK;
        end
        state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

`default_nettype wire

// ----- hw/rtl/fbpa_dp.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator datapath
// Config registers, shared multiplier, slot divider, free list and results.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire fbpa_pkg::fbpa_req_t                 req_i,
  input  wire fbpa_pkg::fbpa_cmd_t                 cmd_i,
  output fbpa_pkg::fbpa_sts_t                      sts_o,
  output fbpa_pkg::fbpa_rsp_t                      rsp_o
);

  import fbpa_pkg::*;

  logic [31:0]           base_q;
  logic [23:0]           region_q;
  logic [STRIDE_W-1:0]   stride_q;
  logic [RSTRIDE_W-1:0]  rstride_q, rstride_d;
  logic [SLOT_W-1:0]     sz_q;
  fbpa_req_t             req_q;
  logic [MUL_A_W-1:0]    mul_a;
  logic [SLOT_W-1:0]     mul_b;
  logic [PROD_W-1:0]     prod_q;
  logic [DIST_W-1:0]     dist_q;
  logic [REM_W-1:0]      rem_q, dvs_q;
  logic [STEP_W-1:0]     step_q;
  logic                  quo_bit;
  logic [SLOT_IDX_W-1:0] slot_q, head_q;
  logic                  empty_q;
  logic [HANDED_W-1:0]   handed_q;
  logic [RAM_W-1:0]      ram_wdata, ram_rdata;
  logic [SLOT_IDX_W-1:0] ram_addr;
  logic                  ram_we;
  logic [SLOT_IDX_W-1:0] rd_link;
  status_e               status_q;
  logic [31:0]           addr_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      region_q <= '0;
      stride_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE:   base_q   <= cfg_wdata_i;
        CFG_REGION: region_q <= cfg_wdata_i[23:0];
        CFG_STRIDE: stride_q <= cfg_wdata_i[STRIDE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Slot geometry, settled well before any use
  assign rstride_d = RSTRIDE_W'((RSTRIDE_W'(stride_q) + RSTRIDE_W'(ALIGN_BYTES - 1))
                                / ALIGN_BYTES * ALIGN_BYTES);

  always_ff @(posedge clk_i) begin
    rstride_q <= rstride_d;
    sz_q      <= SLOT_W'(rstride_q) + SLOT_W'(HEADER_BYTES);
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // Shared multiplier
  always_comb begin
    mul_b = sz_q;
    case (cmd_i.mul_sel)
      MUL_REQ: begin
        mul_a = MUL_A_W'(req_q.item_count);
        mul_b = SLOT_W'(req_q.elem_size);
      end
      MUL_BUMP:  mul_a = MUL_A_W'(handed_q) + MUL_A_W'(1);
      MUL_LIMIT: mul_a = MUL_A_W'(handed_q);
      MUL_SLOT:  mul_a = MUL_A_W'(slot_q);
      default:   mul_a = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // Release offset from the region start, signed
  always_ff @(posedge clk_i) begin
    if (cmd_i.dist_en) begin
      dist_q <= DIST_W'(req_q.payload_address) - DIST_W'(HEADER_BYTES) - DIST_W'(base_q);
    end
  end

  // Restoring divider: one quotient bit per step, quotient lands in slot_q
  assign quo_bit = (rem_q >= dvs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q  <= dist_q[REM_W-1:0];
      dvs_q  <= REM_W'(sz_q) << (SLOT_IDX_W - 1);
      step_q <= STEP_W'(SLOT_IDX_W - 1);
    end else if (cmd_i.div_step) begin
      if (quo_bit) begin
        rem_q <= rem_q - dvs_q;
      end
      dvs_q  <= dvs_q >> 1;
      step_q <= step_q - STEP_W'(1);
    end
  end

  // Slot register: popped head, bump slot or quotient
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_take) begin
      slot_q <= head_q;
    end else if (cmd_i.bump) begin
      slot_q <= handed_q[SLOT_IDX_W-1:0];
    end else if (cmd_i.div_init) begin
      slot_q <= '0;
    end else if (cmd_i.div_step) begin
      slot_q <= SLOT_IDX_W'({slot_q, quo_bit});
    end
  end

  // Link and free flag store
  assign ram_addr  = cmd_i.ram_addr_head ? head_q : slot_q;
  assign ram_we    = cmd_i.mark_used | cmd_i.push;
  assign ram_wdata = cmd_i.push ? {1'b1, (empty_q ? slot_q : head_q)} : {1'b0, slot_q};
  assign rd_link   = ram_rdata[SLOT_IDX_W-1:0];

  fbpa_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Free list head and bump counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      empty_q  <= 1'b1;
      handed_q <= '0;
    end else if (cmd_i.clear) begin
      head_q   <= '0;
      empty_q  <= 1'b1;
      handed_q <= '0;
    end else begin
      if (cmd_i.pop_link) begin
        if (rd_link == slot_q) begin
          empty_q <= 1'b1;
        end else begin
          head_q <= rd_link;
        end
      end
      if (cmd_i.push) begin
        head_q  <= slot_q;
        empty_q <= 1'b0;
      end
      if (cmd_i.bump) begin
        handed_q <= handed_q + HANDED_W'(1);
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= '0;
    end else if (cmd_i.addr_en) begin
      addr_q <= base_q + prod_q[31:0] + 32'(HEADER_BYTES);
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.op          = req_q.operation;
    sts_o.is_null     = req_q.address_is_null;
    sts_o.req_bad     = (req_q.item_count == '0) || (req_q.elem_size == '0) ||
                        (prod_q > PROD_W'(rstride_q));
    sts_o.list_empty  = empty_q;
    sts_o.handed_full = (handed_q >= HANDED_W'(MAX_SLOTS));
    sts_o.bump_over   = (prod_q > PROD_W'(region_q));
    sts_o.range_bad   = dist_q[DIST_W-1] ||
                        (CMP_W'(dist_q[DIST_W-2:0]) >= CMP_W'(prod_q));
    sts_o.div_last    = (step_q == '0);
    sts_o.misaligned  = (rem_q != '0);
    sts_o.double_free = ram_rdata[RAM_W-1];
  end

  assign rsp_o.status          = status_q;
  assign rsp_o.granted_address = addr_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fixed_block_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Hands out and takes back fixed-size slots of a configured byte region.
// ----------------------------------------------------------------------------
// Usage:
//   Program base, region size and stride through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   while the block is idle. Raise start_i with a request on req_i; it is taken
//   at the first edge where busy_o is low. Exactly one result per transaction
//   appears on rsp_o for a single cycle with done_o high; busy_o drops in the
//   cycle after done_o, so a new start can be taken in the cycle after the strobe.
//   Clear, null and unknown codes go from decode straight to done; reserve steps
//   through the size product, check, pop or bump and the address states; release
//   time is set by the restoring divider that finds the slot index one
//   quotient bit per cycle (10 steps for 1024 slots). The single-port link RAM
//   and the shared multiplier are used at most once per step. A new
//   transaction is taken only after the previous one has finished.
//   Reset empties the free list, zeroes the bump counter and config registers;
//   the link RAM is not cleared, so the block is ready right after reset.
//   The receiver cannot stall: results must be taken on the done_o cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire fbpa_pkg::fbpa_req_t             req_i,
  output logic                                 done_o,
  output fbpa_pkg::fbpa_rsp_t                  rsp_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  import fbpa_pkg::*;

  fbpa_cmd_t cmd;
  fbpa_sts_t sts;

  fbpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  fbpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

  // Checks
`include "fixed_block_pool_allocator_assert.svh"

  `FBPA_ASSERT_NEXT(a_accept_starts_work, start_i && !busy_o, busy_o && !done_o, "accepted transaction did not start work")
  `FBPA_ASSERT_SAME(a_done_while_busy, done_o, busy_o, "result strobe outside a transaction")
  `FBPA_ASSERT_NEXT(a_one_result, done_o, !busy_o && !done_o, "more than one result for a transaction")
  `FBPA_ASSERT_SAME(a_fail_no_addr, done_o && (rsp_o.status != ST_OK), rsp_o.granted_address == '0, "failed transaction returned an address")

endmodule

`default_nettype wire

// ----- sim/fixed_block_pool_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Runs a table of directed reserve, release and clear requests, then several
// configuration phases of random traffic. A cycle-free pool model predicts
// every unpinned response; responses are checked in order, field by field.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Directed table row: request plus an optional typed-in response
  typedef struct {
    fbpa_req_t req;
    bit        pinned;
    fbpa_rsp_t rsp;
  } probe_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  fbpa_req_t             req_i = '0;
  logic                  done_o;
  fbpa_rsp_t             rsp_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Pool model state
  logic [31:0]           pool_base = '0;
  logic [23:0]           pool_region = '0;
  logic [15:0]           pool_stride = '0;
  bit [SLOT_IDX_W-1:0]   link_mem [MAX_SLOTS];
  bit                    on_free_list [MAX_SLOTS];
  logic [SLOT_IDX_W-1:0] fl_head = '0;
  logic                  list_empty = 1'b1;
  logic [HANDED_W-1:0]   handed = '0;

  fbpa_rsp_t             pending_rsp [$];
  logic [31:0]           held_addrs [$];
  logic [31:0]           freed_addrs [$];
  probe_row_t            dir_tbl [$];
  int                    err_count = 0;
  bit                    steady = 1'b0;

  fixed_block_pool_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Payload bytes per slot after alignment rounding
  function automatic longint unsigned padded_stride();
    longint unsigned s;
    s = 64'(pool_stride);
    return ((s + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  // Pool model: applies one transaction and returns its response
  function automatic fbpa_rsp_t pool_predict(input fbpa_req_t r);
    fbpa_rsp_t             res;
    longint unsigned       pad;
    longint unsigned       sz;
    longint unsigned       prod;
    longint unsigned       span;
    longint unsigned       full;
    longint unsigned       udist;
    longint unsigned       quot;
    longint                offs;
    longint                base_l;
    logic [SLOT_IDX_W-1:0] slot;
    res.status = ST_OK;
    res.granted_address = '0;
    pad = padded_stride();
    sz = HEADER_BYTES + pad;
    slot = '0;
    case (r.operation)
      OP_RESERVE: begin
        prod = 64'(r.item_count);
        prod = prod * r.elem_size;
        span = 64'(handed);
        span = (span + 1) * sz;
        if (r.item_count == 0 || r.elem_size == 0 || prod > pad) begin
          res.status = ST_BAD_REQ;
        end else if (!list_empty) begin
          // pop the most recently released slot
          slot = fl_head;
          if (link_mem[slot] == slot) list_empty = 1'b1;
          else fl_head = link_mem[slot];
        end else if (handed >= MAX_SLOTS || span > pool_region) begin
          res.status = ST_EXHAUSTED;
        end else begin
          slot = handed[SLOT_IDX_W-1:0];
          handed = handed + 1'b1;
        end
        if (res.status == ST_OK) begin
          on_free_list[slot] = 1'b0;
          full = 64'(pool_base);
          full = full + slot * sz + HEADER_BYTES;
          res.granted_address = full[31:0];
        end
      end
      OP_RELEASE: begin
        offs = 64'(r.payload_address);
        base_l = 64'(pool_base);
        offs = offs - HEADER_BYTES - base_l;
        udist = offs;
        span = 64'(handed);
        span = span * sz;
        if (r.address_is_null) begin
          res.status = ST_NULL;
        end else if (offs < 0 || udist >= span) begin
          res.status = ST_RANGE;
        end else if (udist % sz != 0) begin
          res.status = ST_MISALIGNED;
        end else begin
          quot = udist / sz;
          slot = quot[SLOT_IDX_W-1:0];
          if (quot >= MAX_SLOTS) res.status = ST_RANGE;
          else if (on_free_list[slot]) res.status = ST_DOUBLE_FREE;
          else begin
            on_free_list[slot] = 1'b1;
            link_mem[slot] = list_empty ? slot : fl_head;
            fl_head = slot;
            list_empty = 1'b0;
          end
        end
      end
      OP_CLEAR: begin
        handed = '0;
        fl_head = '0;
        list_empty = 1'b1;
      end
      default: res.status = ST_BAD_REQ;
    endcase
    return res;
  endfunction

  function automatic probe_row_t dir_row(input logic [1:0] op, input logic [15:0] cnt,
                                         input logic [15:0] esz, input logic [31:0] addr,
                                         input logic nul, input bit pin,
                                         input status_e st, input logic [31:0] ga);
    probe_row_t row;
    row.req.operation = op;
    row.req.item_count = cnt;
    row.req.elem_size = esz;
    row.req.payload_address = addr;
    row.req.address_is_null = nul;
    row.pinned = pin;
    row.rsp.status = st;
    row.rsp.granted_address = ga;
    return row;
  endfunction

  // Register write, mirrored into the model; write enable left high
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_BASE:   pool_base = data;
      CFG_REGION: pool_region = data[23:0];
      CFG_STRIDE: pool_stride = data[15:0];
      default: ;
    endcase
  endtask

  // Wait until every response has come back and the block is idle
  task automatic drain();
    do @(posedge clk_i); while (pending_rsp.size() != 0 || busy_o);
  endtask

  // Issue one transaction and record the response it must produce
  task automatic send_txn(input fbpa_req_t r, input bit pinned, input fbpa_rsp_t pin);
    fbpa_rsp_t got;
    int        k;
    int        hit;
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    got = pool_predict(r);
    pending_rsp.push_back(pinned ? pin : got);
    // track handed-out addresses to build well-formed releases
    if (r.operation == OP_RESERVE && got.status == ST_OK) begin
      held_addrs.push_back(got.granted_address);
    end else if (r.operation == OP_RELEASE && got.status == ST_OK) begin
      hit = -1;
      for (k = 0; k < held_addrs.size(); k++) begin
        if (held_addrs[k] == r.payload_address) hit = k;
      end
      if (hit >= 0) held_addrs.delete(hit);
      freed_addrs.push_back(r.payload_address);
      if (freed_addrs.size() > 32) void'(freed_addrs.pop_front());
    end else if (r.operation == OP_CLEAR) begin
      held_addrs.delete();
      freed_addrs.delete();
    end
  endtask

  // Random sender gaps, mostly short, with stretches of back-to-back traffic
  task automatic idle_gap();
    int n;
    int pick;
    if ($urandom_range(0, 49) == 0) steady = !steady;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) n = 0;
    else if (pick < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n != 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Response checker
  always @(posedge clk_i) begin
    fbpa_rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        err_count++;
        if (err_count <= 50)
          $display("%0t: unexpected response, expected none, got status %0d address %h",
                   $time, rsp_o.status, rsp_o.granted_address);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status) begin
          err_count++;
          if (err_count <= 50)
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, rsp_o.status);
        end
        if (rsp_o.granted_address !== want.granted_address) begin
          err_count++;
          if (err_count <= 50)
            $display("%0t: granted_address mismatch, expected %h got %h",
                     $time, want.granted_address, rsp_o.granted_address);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // Stimulus
  initial begin
    fbpa_req_t       req;
    fbpa_rsp_t       no_rsp;
    longint unsigned pad;
    int unsigned     cap;
    int              ph;
    int              k;
    int              pick;
    int              n_items;
    int              res_pct;
    int              clr_pct;
    bit              clr_first;
    logic [31:0]     ph_base;
    logic [23:0]     ph_region;
    logic [15:0]     ph_stride;

    no_rsp = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // Directed part: 48-byte slots, five fit in the region
    write_reg(CFG_BASE, 32'h0000_1000);
    write_reg(CFG_REGION, 32'h0000_0100);
    write_reg(CFG_STRIDE, 32'd20);
    cfg_we_i <= 1'b0;

    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd0, 16'd5, '0, 1'b0, 1'b1, ST_BAD_REQ, '0));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd5, 16'd0, '0, 1'b0, 1'b1, ST_BAD_REQ, '0));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'hFFFF, 16'hFFFF, '0, 1'b0, 1'b1, ST_BAD_REQ, '0));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd1, 16'd32, '0, 1'b0, 1'b1, ST_OK, 32'h1010));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd33, 16'd1, '0, 1'b0, 1'b1, ST_BAD_REQ, '0));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd2, 16'd16, '0, 1'b0, 1'b1, ST_OK, 32'h1040));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd1, 16'd1, '0, 1'b0, 1'b1, ST_OK, 32'h1070));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd4, 16'd8, '0, 1'b0, 1'b1, ST_OK, 32'h10A0));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd1, 16'd1, '0, 1'b0, 1'b1, ST_OK, 32'h10D0));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd1, 16'd1, '0, 1'b0, 1'b1, ST_EXHAUSTED, '0));
    dir_tbl.push_back(dir_row(OP_RELEASE, '0, '0, 32'h1040, 1'b1, 1'b1, ST_NULL, '0));
    dir_tbl.push_back(dir_row(OP_RELEASE, '0, '0, 32'h0, 1'b0, 1'b1, ST_RANGE, '0));
    dir_tbl.push_back(dir_row(OP_RELEASE, '0, '0, 32'h1100, 1'b0, 1'b1, ST_RANGE, '0));
    dir_tbl.push_back(dir_row(OP_RELEASE, '0, '0, 32'h1041, 1'b0, 1'b1, ST_MISALIGNED, '0));
    dir_tbl.push_back(dir_row(OP_RELEASE, '0, '0, 32'h1040, 1'b0, 1'b0, ST_OK, '0));
    dir_tbl.push_back(dir_row(OP_RELEASE, '0, '0, 32'h1040, 1'b0, 1'b1, ST_DOUBLE_FREE, '0));
    dir_tbl.push_back(dir_row(OP_RELEASE, '0, '0, 32'h1010, 1'b0, 1'b0, ST_OK, '0));
    // free list hands slots back last-in first-out
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd1, 16'd1, '0, 1'b0, 1'b0, ST_OK, '0));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd1, 16'd1, '0, 1'b0, 1'b0, ST_OK, '0));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd1, 16'd1, '0, 1'b0, 1'b1, ST_EXHAUSTED, '0));
    dir_tbl.push_back(dir_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                              ST_BAD_REQ, '0));
    dir_tbl.push_back(dir_row(OP_CLEAR, '0, '0, '0, 1'b0, 1'b1, ST_OK, '0));
    dir_tbl.push_back(dir_row(OP_RESERVE, 16'd1, 16'd1, '0, 1'b0, 1'b1, ST_OK, 32'h1010));
    dir_tbl.push_back(dir_row(OP_RELEASE, '0, '0, 32'hFFFF_FFFF, 1'b0, 1'b1, ST_RANGE, '0));
    dir_tbl.push_back(dir_row(OP_CLEAR, '0, '0, '0, 1'b0, 1'b1, ST_OK, '0));

    foreach (dir_tbl[i]) begin
      send_txn(dir_tbl[i].req, dir_tbl[i].pinned, dir_tbl[i].rsp);
      idle_gap();
    end

    // Random phases, each with its own register settings
    for (ph = 0; ph < 5; ph++) begin
      start_i <= 1'b0;
      drain();
      case (ph)
        0: begin
          ph_base = '0; ph_region = '0; ph_stride = '0;
          n_items = 60; res_pct = 50; clr_pct = 5; clr_first = 1'b0;
        end
        1: begin
          ph_base = $urandom; ph_region = 24'd1536; ph_stride = 16'($urandom_range(1, 100));
          n_items = 120; res_pct = 55; clr_pct = 3; clr_first = 1'b1;
        end
        2: begin
          // live slots from the last phase stay, geometry changes under them
          ph_base = 32'hFFFF_FFFF; ph_region = 24'hFF_FFFF; ph_stride = 16'hFFFF;
          n_items = 150; res_pct = 60; clr_pct = 2; clr_first = 1'b0;
        end
        3: begin
          // fill run: mostly reserves into a large region, filling towards the slot count limit
          ph_base = 32'h8000_0000; ph_region = 24'hFF_FFFF;
          ph_stride = 16'($urandom_range(1, 16));
          n_items = 1100; res_pct = 97; clr_pct = 0; clr_first = 1'b1;
        end
        default: begin
          ph_base = 32'hFFFF_FF00; ph_region = 24'($urandom_range(0, 16'hFFFF));
          ph_stride = 16'($urandom_range(0, 300));
          n_items = 200; res_pct = 50; clr_pct = 3; clr_first = 1'b0;
        end
      endcase
      write_reg(CFG_BASE, ph_base);
      write_reg(CFG_REGION, {8'h00, ph_region});
      write_reg(CFG_STRIDE, {16'h0000, ph_stride});
      cfg_we_i <= 1'b0;

      if (clr_first) begin
        req = '0;
        req.operation = OP_CLEAR;
        send_txn(req, 1'b0, no_rsp);
        idle_gap();
      end

      for (k = 0; k < n_items; k++) begin
        req.operation = OP_RELEASE;
        req.item_count = 16'($urandom_range(0, 16'hFFFF));
        req.elem_size = 16'($urandom_range(0, 16'hFFFF));
        req.payload_address = $urandom;
        req.address_is_null = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < res_pct) req.operation = OP_RESERVE;
        else if (pick < res_pct + clr_pct) req.operation = OP_CLEAR;
        else if (pick < res_pct + clr_pct + 1) req.operation = OP_UNUSED;

        if (req.operation == OP_RESERVE) begin
          pad = padded_stride();
          if (pad != 0 && $urandom_range(0, 99) < 85) begin
            // fits the rounded stride
            cap = (pad > 65535) ? 32'd65535 : 32'(pad);
            req.item_count = ($urandom_range(0, 1) == 0) ? 16'd1
                                                         : 16'($urandom_range(1, cap));
            cap = 32'(pad / req.item_count);
            if (cap > 65535) cap = 65535;
            req.elem_size = 16'($urandom_range(1, cap));
          end
        end else if (req.operation == OP_RELEASE) begin
          pick = $urandom_range(0, 99);
          if (pick < 60 && held_addrs.size() != 0) begin
            req.payload_address = held_addrs[$urandom_range(0, held_addrs.size() - 1)];
          end else if (pick < 70 && freed_addrs.size() != 0) begin
            req.payload_address = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
          end else if (pick < 80 && held_addrs.size() != 0) begin
            req.payload_address = held_addrs[$urandom_range(0, held_addrs.size() - 1)]
                                  + $urandom_range(1, 15);
          end else if (pick < 85) begin
            req.address_is_null = 1'b1;
          end
        end else if ($urandom_range(0, 1) == 0) begin
          req.address_is_null = 1'b1;
        end

        // occasionally hold off until all responses are back
        if ($urandom_range(0, 99) == 0) begin
          start_i <= 1'b0;
          drain();
        end
        send_txn(req, 1'b0, no_rsp);
        idle_gap();
      end
    end

    start_i <= 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
